/* rtl/nlp_pkg.sv */
// Shared types, character codes and the digit decoder for the numeric literal parser.
// No dependencies; every other file in this folder imports it.
package nlp_pkg;

  localparam int unsigned ValueW = 32;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_X     = 8'd120;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LF    = 8'd102;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UF    = 8'd70;
  localparam logic [7:0] LOWER_OFFSET = 8'd87;
  localparam logic [7:0] UPPER_OFFSET = 8'd55;

  // Operation codes passed from the front end to the back end.
  localparam logic [2:0] OP_DIGIT = 3'd0;
  localparam logic [2:0] OP_NEG   = 3'd1;
  localparam logic [2:0] OP_HEX   = 3'd2;
  localparam logic [2:0] OP_FAIL  = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic       hex;
    logic [3:0] digit;
  } op_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_decode(input logic [7:0] c, input logic hex);
    digit_t d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff = c - CH_ZERO;
      d.ok = 1'b1;
    end else if (hex && c >= CH_LA && c <= CH_LF) begin
      diff = c - LOWER_OFFSET;
      d.ok = 1'b1;
    end else if (hex && c >= CH_UA && c <= CH_UF) begin
      diff = c - UPPER_OFFSET;
      d.ok = 1'b1;
    end
    d.val = diff[3:0];
    return d;
  endfunction

endpackage

/* rtl/nlp_front.sv */
// Front end: accepts characters and classifies each into one back-end operation.
// Depends on nlp_pkg.
module nlp_front import nlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_code,
  output op_t        op
);

  logic [1:0] char_position;
  logic       first_was_zero;
  logic       hex_mode;
  digit_t     dig;

  always_comb begin
    dig      = digit_decode(char_code, hex_mode);
    op.hex   = hex_mode;
    op.digit = dig.val;
    if (char_code == CH_NUL) begin
      op.kind = OP_END;
    end else if (char_position == 2'd0 && char_code == CH_MINUS) begin
      op.kind = OP_NEG;
    end else if (char_position == 2'd1 && first_was_zero && char_code == CH_X) begin
      op.kind = OP_HEX;
    end else if (char_position == 2'd2 && hex_mode && char_code == CH_MINUS) begin
      op.kind = OP_NEG;
    end else if (dig.ok) begin
      op.kind = OP_DIGIT;
    end else begin
      op.kind = OP_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= '0;
      first_was_zero <= 1'b0;
      hex_mode       <= 1'b0;
    end else if (take) begin
      if (op.kind == OP_END) begin
        char_position  <= '0;
        first_was_zero <= 1'b0;
        hex_mode       <= 1'b0;
      end else begin
        if (char_position != 2'd3) char_position <= char_position + 2'd1;
        if (char_position == 2'd0 && char_code == CH_ZERO) first_was_zero <= 1'b1;
        if (op.kind == OP_HEX) hex_mode <= 1'b1;
      end
    end
  end

endmodule

/* rtl/nlp_queue.sv */
// Two-entry queue of operations between the front end and the back end.
// Depends on nlp_pkg.
module nlp_queue import nlp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t        slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_op    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/nlp_back.sv */
// Back end: applies operations to the accumulator and holds the result register.
// Depends on nlp_pkg.
module nlp_back import nlp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  op_t               head_op,
  output logic              pop,
  output logic              value_valid,
  input  logic              value_stall,
  output logic [ValueW-1:0] value
);

  logic [ValueW-1:0] accumulator;
  logic [ValueW-1:0] accumulator_next;
  logic              is_negative;
  logic              has_failed;
  logic              out_free;
  logic              pop_end;
  logic [ValueW-1:0] result;
  logic [ValueW-1:0] digit_ext;

  assign out_free  = !value_valid || !value_stall;
  assign pop       = head_valid && (head_op.kind != OP_END || out_free);
  assign pop_end   = pop && head_op.kind == OP_END;
  assign digit_ext = {{(ValueW-4){1'b0}}, head_op.digit};
  assign result    = has_failed ? '0
                   : (is_negative ? (~accumulator + {{(ValueW-1){1'b0}}, 1'b1})
                                  : accumulator);

  always_comb begin
    if (head_op.hex) begin
      accumulator_next = {accumulator[ValueW-5:0], 4'b0000} + digit_ext;
    end else begin
      accumulator_next = {accumulator[ValueW-4:0], 3'b000}
                       + {accumulator[ValueW-2:0], 1'b0} + digit_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      is_negative <= 1'b0;
      has_failed  <= 1'b0;
    end else if (pop) begin
      unique case (head_op.kind)
        OP_DIGIT: accumulator <= accumulator_next;
        OP_NEG:   is_negative <= 1'b1;
        OP_HEX:   accumulator <= '0;
        OP_FAIL:  has_failed  <= 1'b1;
        default: begin
          accumulator <= '0;
          is_negative <= 1'b0;
          has_failed  <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else if (pop_end) begin
      value_valid <= 1'b1;
    end else if (value_valid && !value_stall) begin
      value_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_end) value <= result;
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    pop_end |=> accumulator == '0 && !is_negative && !has_failed)
    else $error("state not cleared after terminator");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pop_end |-> out_free)
    else $error("result register overwritten while held");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    pop_end && has_failed |=> value_valid && value == '0)
    else $error("failed literal did not give zero");

endmodule

/* rtl/numeric_literal_parser.sv */
// Top level of the numeric literal parser: front end, operation queue, back end.
// Depends on nlp_pkg, nlp_front, nlp_queue and nlp_back.
//
// The block takes one ASCII character per transfer on the char channel and, when the
// zero terminator arrives, returns the 32-bit signed value of the literal on the value
// channel. A leading "0x" selects hexadecimal (0-9, a-f, A-F) with an optional minus
// sign directly after it; otherwise the literal is decimal with an optional leading
// minus sign. Any invalid character, including bytes above 127, makes the result zero,
// as does an empty string. Arithmetic wraps modulo 2^32. One character is taken every
// clock cycle unless the queue is full: the front end classifies it in the cycle of its
// transfer, and the back end applies one operation per cycle, unless a terminator waits
// for the result register, updating the accumulator with shifts and adds. The
// terminator's operation passes through the queue to the back end, which loads the
// result register when it takes it. A two-entry queue and the result register let
// characters keep flowing while a result waits.
module numeric_literal_parser import nlp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  logic [7:0]        char_code,
  output logic              value_valid,
  input  logic              value_stall,
  output logic signed [ValueW-1:0] value
);

  logic              take;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  op_t               front_op;
  op_t               q_op;
  logic [ValueW-1:0] value_raw;

  // The front end stalls only when the queue is full.
  assign char_stall = q_full;
  assign take       = char_valid && !q_full;
  assign value      = signed'(value_raw);

  nlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .op        (front_op)
  );

  nlp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_op    (front_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_op)
  );

  nlp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_valid),
    .head_op     (q_op),
    .pop         (q_pop),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value_raw)
  );

endmodule

/* verif/nlp_checker.sv */
`timescale 1ns / 1ps
// Checker for the numeric literal parser: watches both channels, predicts each value
// and compares it with what the block returns. Depends on nlp_pkg only.
module nlp_checker import nlp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     char_valid,
  input  logic                     char_stall,
  input  logic [7:0]               char_code,
  input  logic                     value_valid,
  input  logic                     value_stall,
  input  logic signed [ValueW-1:0] value,
  output int                       mismatch_count,
  output int                       pending_count
);

  // Predicted parser state.
  logic [1:0]        seen_count;
  logic              lead_zero;
  logic              hex_seen;
  logic              minus_seen;
  logic              bad_char;
  logic [ValueW-1:0] acc;

  logic signed [ValueW-1:0] parsed_values[$];
  int                       errors;

  initial begin
    errors = 0;
  end

  function automatic int digit_weight(input logic [7:0] c, input logic hex);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (hex && c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (hex && c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  task automatic clear_parse();
    seen_count = 2'd0;
    lead_zero  = 1'b0;
    hex_seen   = 1'b0;
    minus_seen = 1'b0;
    bad_char   = 1'b0;
    acc        = '0;
  endtask

  task automatic add_digit(input logic [7:0] c);
    int d;
    d = digit_weight(c, hex_seen);
    if (d < 0) begin
      bad_char = 1'b1;
    end else if (hex_seen) begin
      acc = {acc[ValueW-5:0], 4'b0000} + ValueW'(d);
    end else begin
      acc = acc * ValueW'(10) + ValueW'(d);
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [ValueW-1:0] v;
    if (c == CH_NUL) begin
      v = '0;
      if (!bad_char) v = minus_seen ? ValueW'(0) - acc : acc;
      parsed_values.push_back(v);
      clear_parse();
    end else begin
      if (seen_count == 2'd0) begin
        if (c == CH_MINUS) begin
          minus_seen = 1'b1;
        end else begin
          if (c == CH_ZERO) lead_zero = 1'b1;
          add_digit(c);
        end
      end else if (seen_count == 2'd1 && lead_zero && c == CH_X) begin
        hex_seen = 1'b1;
        acc      = '0;
      end else if (seen_count == 2'd2 && hex_seen && c == CH_MINUS) begin
        minus_seen = 1'b1;
      end else begin
        add_digit(c);
      end
      if (seen_count != 2'd3) seen_count = seen_count + 2'd1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      parsed_values.delete();
    end else begin
      // A result leaving at this edge belongs to an earlier terminator, so it is
      // checked before this edge's character is applied.
      if (value_valid && !value_stall) begin
        if (parsed_values.size() == 0) begin
          if (errors < 10) $display("%0t: value %0d returned with none expected", $realtime, value);
          errors++;
        end else begin
          if (value !== parsed_values[0]) begin
            if (errors < 10)
              $display("%0t: value mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                       $realtime, parsed_values[0], parsed_values[0], value, value);
            errors++;
          end
          void'(parsed_values.pop_front());
        end
      end
      if (char_valid && !char_stall) parse_char(char_code);
    end
    mismatch_count <= errors;
    pending_count  <= parsed_values.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top of the numeric literal parser testbench: clock, reset, stimulus and verdict.
// Depends on nlp_pkg, the parser RTL and nlp_checker.
module testbench;
  import nlp_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     char_valid;
  logic                     char_stall;
  logic [7:0]               char_code;
  logic                     value_valid;
  logic                     value_stall;
  logic signed [ValueW-1:0] value;

  int mismatch_count;
  int pending_count;

  // Characters of the literal being sent, without its terminator.
  logic [7:0] lit[$];
  int         burst_left;
  int         chars_sent;

  numeric_literal_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value)
  );

  nlp_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_code      (char_code),
    .value_valid    (value_valid),
    .value_stall    (value_stall),
    .value          (value),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A generous bound on the whole run. Even with every result held by the slowest
  // stall pattern and every burst followed by its longest gap, a correct run needs
  // well under a tenth of this.
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one character and returns at the edge of its transfer. The sender works in
  // bursts: when a burst is used up, valid is dropped for a random gap first. Valid is
  // only ever assigned once per time step, because the next character is driven in the
  // same step as the transfer of the previous one.
  task automatic send_char(input logic [7:0] c);
    if (burst_left == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Now and then a long burst gives a stretch with no idling on the sending side.
      burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 40);
    end
    char_valid <= 1'b1;
    char_code  <= c;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_literal();
    foreach (lit[i]) send_char(lit[i]);
    send_char(CH_NUL);
  endtask

  task automatic send_text(input string s);
    lit.delete();
    for (int i = 0; i < s.len(); i++) lit.push_back(s[i]);
    send_literal();
  endtask

  // Builds one random literal. Most are well formed, decimal or hexadecimal, so that
  // the accumulator sees long runs of digits and wraps; some are corrupted by one byte
  // (replaced or inserted), and a few are pure noise or empty.
  task automatic build_random_literal();
    int         kind;
    int         n;
    int         d;
    int         pos;
    logic [7:0] junk;
    lit.delete();
    kind = $urandom_range(0, 99);
    if (kind < 94) begin
      if (kind < 40 || (kind >= 80 && kind < 87)) begin
        if ($urandom_range(0, 2) == 0) lit.push_back(CH_MINUS);
        n = (kind < 40) ? $urandom_range(1, 11) : $urandom_range(1, 5);
        repeat (n) lit.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        lit.push_back(CH_ZERO);
        lit.push_back(CH_X);
        if ($urandom_range(0, 2) == 0) lit.push_back(CH_MINUS);
        n = (kind < 80) ? $urandom_range(0, 9) : $urandom_range(1, 4);
        repeat (n) begin
          d = $urandom_range(0, 15);
          if (d < 10) lit.push_back(CH_ZERO + 8'(d));
          else if ($urandom_range(0, 1) == 0) lit.push_back(CH_LA + 8'(d - 10));
          else lit.push_back(CH_UA + 8'(d - 10));
        end
      end
      if (kind >= 80) begin
        // Corrupt the literal: the junk byte is often a minus sign or a near-miss
        // letter so that it lands on the positions where those are tested.
        case ($urandom_range(0, 3))
          0:       junk = CH_MINUS;
          1:       junk = 8'($urandom_range(CH_LF + 1, 8'd122));
          default: junk = 8'($urandom_range(1, 255));
        endcase
        pos = $urandom_range(0, lit.size());
        if (pos < lit.size() && $urandom_range(0, 1) == 0) lit[pos] = junk;
        else lit.insert(pos, junk);
      end
    end else begin
      n = $urandom_range(0, 4);
      repeat (n) lit.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // The receiver stalls on a pattern of its own that it picks anew at random: never, rarely,
  // mostly, or alternating. Once in the run it holds off for a long stretch while the
  // sender carries on, so that the block fills and stalls.
  initial begin
    int cycle_count;
    int mode;
    int mode_left;
    cycle_count = 0;
    mode        = 0;
    mode_left   = 0;
    value_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count == 800) begin
        value_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (mode)
        0:       value_stall <= 1'b0;
        1:       value_stall <= ($urandom_range(0, 3) == 0);
        2:       value_stall <= ($urandom_range(0, 3) != 0);
        default: value_stall <= ~value_stall;
      endcase
    end
  end

  initial begin
    int wait_count;
    rst        <= 1'b1;
    char_valid <= 1'b0;
    char_code  <= CH_NUL;
    burst_left = 0;
    chars_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed literals: the empty string, a lone zero, the bare prefixes, the signed
    // extremes in decimal, all ones and the minimum in hex, wrapping in the accumulator
    // and the negation, both hex letter cases, and misplaced minus signs and letters.
    send_text("");
    send_text("0");
    send_text("0x-");
    send_text("-");
    send_text("2147483647");
    send_text("-2147483648");
    send_text("4294967297");
    send_text("0xFFFFFFFF");
    send_text("0x-80000000");
    send_text("0xaBcDeF");
    send_text("-0x1");
    send_text("0X1");
    send_text("1-2");
    send_text("0xg");
    // Bytes with the top bit set are never valid characters.
    lit = '{CH_ZERO, CH_X, 8'hC8};
    send_literal();
    lit = '{8'hFF};
    send_literal();

    chars_sent = 0;
    while (chars_sent < 1400) begin
      build_random_literal();
      send_literal();
    end
    char_valid <= 1'b0;

    // The checker's counts are registered copies of its view, so the last terminator is only
    // counted from the next edge on. Let every outstanding value come back, then keep
    // watching the value channel in case the block returns something it should not.
    @(posedge clk);
    wait_count = 0;
    while (pending_count != 0 && wait_count < 20000) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (10) @(posedge clk);

    if (pending_count != 0) $display("%0d expected values never returned", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
